// ===== design/aesl_pkg.sv =====
`timescale 1ns / 1ps

package aesl_pkg;

   // escape tracking codes
   localparam logic [2:0] ESC_GROUND  = 3'd0;
   localparam logic [2:0] ESC_SEEN    = 3'd1;
   localparam logic [2:0] ESC_CSI     = 3'd2;
   localparam logic [2:0] ESC_STR     = 3'd3;
   localparam logic [2:0] ESC_STR_ESC = 3'd4;

   // input op codes
   localparam logic OP_DATA  = 1'b0;
   localparam logic OP_CLOSE = 1'b1;

   // result kinds
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_MARKER = 1'b1;

   // byte values
   localparam logic [7:0] CHR_BEL       = 8'h07;
   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_LF        = 8'h0a;
   localparam logic [7:0] CHR_ESC       = 8'h1b;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_FINAL_LO  = 8'h40;
   localparam logic [7:0] CHR_FINAL_HI  = 8'h7e;
   localparam logic [7:0] CHR_LBRACKET  = 8'h5b;
   localparam logic [7:0] CHR_RBRACKET  = 8'h5d;
   localparam logic [7:0] CHR_UPPER_P   = 8'h50;
   localparam logic [7:0] CHR_UPPER_X   = 8'h58;
   localparam logic [7:0] CHR_CARET     = 8'h5e;
   localparam logic [7:0] CHR_UNDERLINE = 8'h5f;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5c;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic       last;
   } result_type;

   // results produced by one item, up to two
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== design/ansi_escape_strip_line_stamper_top.sv =====
`timescale 1ns / 1ps

// ANSI escape stripper with per-line timestamp-prefix markers. Each request
// transfer carries one terminal byte (op data) or a close (op close). Escape
// sequences (two-byte ESC, CSI up to a final byte 0x40..0x7e, and OSC/DCS/
// SOS/PM/APC strings ended by BEL or ESC backslash) are dropped, as are
// control bytes below 0x20 other than LF and TAB. With csr_prefix_enable set
// (reset value 1) the first kept byte of every line is preceded by a marker
// result (kind 1, out_byte zero). A close emits a trailing LF when a line is
// unfinished and returns the tracker to line start. rsp_last flags the final
// result of each request. Rate: one request per cycle while the response
// queue has room; a request producing a marker plus a byte pushes two
// results, so sustained input rate is set by the one-result-per-cycle
// response queue. Requests pass the input register, then a four-entry
// response queue. Write the prefix register only while idle.

module ansi_escape_strip_line_stamper_top (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_in_byte,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   // configuration write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_prefix_enable
);

   logic                 prefix_enable_ff;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic                 in_op_ff;
   logic [7:0]           in_byte_ff;
   logic                 req_accept;
   logic                 fire;
   logic                 space_ok;
   aesl_pkg::push_type   push;
   aesl_pkg::result_type head;

   // config register always takes its transfer
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         prefix_enable_ff <= csr_prefix_enable;
      end
   end

   // input register: holds while the queue lacks room for a burst
   assign req_stall  = in_valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_in_byte;
      end
   end

   // escape tracking and result formation
   aesl_strip u_strip (
      .clock         (clock),
      .reset         (reset),
      .prefix_enable (prefix_enable_ff),
      .item_valid    (in_valid_ff),
      .item_op       (in_op_ff),
      .item_byte     (in_byte_ff),
      .space_ok      (space_ok),
      .fire          (fire),
      .push          (push)
   );

   // response queue decouples the two sides
   aesl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind     = head.kind;
   assign rsp_out_byte = head.out_byte;
   assign rsp_last     = head.last;

endmodule

// ===== design/aesl_strip.sv =====
`timescale 1ns / 1ps

module aesl_strip (
   input  logic               clock,
   input  logic               reset,
   input  logic               prefix_enable,
   input  logic               item_valid,
   input  logic               item_op,
   input  logic [7:0]         item_byte,
   input  logic               space_ok,
   output logic               fire,
   output aesl_pkg::push_type push
);

   logic [2:0] esc_ff;
   logic [2:0] esc_in;
   logic       line_start_ff;
   logic       line_start_in;
   logic       keep;

   assign fire = item_valid && space_ok;

   always_comb begin
      esc_in        = esc_ff;
      line_start_in = line_start_ff;
      keep          = 1'b0;
      push          = '0;
      if (item_op == aesl_pkg::OP_CLOSE) begin
         if (!line_start_ff) begin
            push.count          = 2'd1;
            push.first.kind     = aesl_pkg::KIND_BYTE;
            push.first.out_byte = aesl_pkg::CHR_LF;
            push.first.last     = 1'b1;
         end
         esc_in        = aesl_pkg::ESC_GROUND;
         line_start_in = 1'b1;
      end else begin
         unique case (esc_ff)
            aesl_pkg::ESC_SEEN: begin
               if (item_byte == aesl_pkg::CHR_LBRACKET) begin
                  esc_in = aesl_pkg::ESC_CSI;
               end else if (item_byte == aesl_pkg::CHR_RBRACKET
                            || item_byte == aesl_pkg::CHR_UPPER_P
                            || item_byte == aesl_pkg::CHR_UPPER_X
                            || item_byte == aesl_pkg::CHR_CARET
                            || item_byte == aesl_pkg::CHR_UNDERLINE) begin
                  esc_in = aesl_pkg::ESC_STR;
               end else begin
                  esc_in = aesl_pkg::ESC_GROUND;
               end
            end
            aesl_pkg::ESC_CSI: begin
               if (item_byte >= aesl_pkg::CHR_FINAL_LO && item_byte <= aesl_pkg::CHR_FINAL_HI) begin
                  esc_in = aesl_pkg::ESC_GROUND;
               end
            end
            aesl_pkg::ESC_STR: begin
               if (item_byte == aesl_pkg::CHR_BEL) begin
                  esc_in = aesl_pkg::ESC_GROUND;
               end else if (item_byte == aesl_pkg::CHR_ESC) begin
                  esc_in = aesl_pkg::ESC_STR_ESC;
               end
            end
            aesl_pkg::ESC_STR_ESC: begin
               esc_in = (item_byte == aesl_pkg::CHR_BACKSLASH) ?
                        aesl_pkg::ESC_GROUND : aesl_pkg::ESC_STR;
            end
            default: begin
               // ground, unused codes fall back here too
               esc_in = aesl_pkg::ESC_GROUND;
               if (item_byte == aesl_pkg::CHR_ESC) begin
                  esc_in = aesl_pkg::ESC_SEEN;
               end else if (item_byte >= aesl_pkg::CHR_SPACE
                            || item_byte == aesl_pkg::CHR_LF
                            || item_byte == aesl_pkg::CHR_TAB) begin
                  keep = 1'b1;
               end
            end
         endcase
         if (keep) begin
            line_start_in = (item_byte == aesl_pkg::CHR_LF);
            if (line_start_ff && prefix_enable) begin
               push.count           = 2'd2;
               push.first.kind      = aesl_pkg::KIND_MARKER;
               push.first.out_byte  = 8'h00;
               push.first.last      = 1'b0;
               push.second.kind     = aesl_pkg::KIND_BYTE;
               push.second.out_byte = item_byte;
               push.second.last     = 1'b1;
            end else begin
               push.count          = 2'd1;
               push.first.kind     = aesl_pkg::KIND_BYTE;
               push.first.out_byte = item_byte;
               push.first.last     = 1'b1;
            end
         end
      end
      if (!fire) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff        <= aesl_pkg::ESC_GROUND;
         line_start_ff <= 1'b1;
      end else if (fire) begin
         esc_ff        <= esc_in;
         line_start_ff <= line_start_in;
      end
   end

   close_resets_state: assert property (@(posedge clock) disable iff (reset)
      fire && item_op == aesl_pkg::OP_CLOSE |=>
         esc_ff == aesl_pkg::ESC_GROUND && line_start_ff)
      else $error("close did not return to line start in ground");

   marker_needs_line_start: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> line_start_ff && prefix_enable
         && push.first.kind == aesl_pkg::KIND_MARKER)
      else $error("marker pushed away from line start");

endmodule

// ===== design/aesl_rsp_queue.sv =====
`timescale 1ns / 1ps

module aesl_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  aesl_pkg::push_type   push,
   output logic                 space_ok,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aesl_pkg::result_type head
);

   aesl_pkg::result_type entry_ff [aesl_pkg::QUEUE_DEPTH];

   logic [aesl_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [aesl_pkg::QPTR_W-1:0] wr_ptr_in;
   logic [aesl_pkg::QPTR_W-1:0] wr_next;
   logic [aesl_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [aesl_pkg::QPTR_W-1:0] rd_ptr_in;
   logic [aesl_pkg::QCNT_W-1:0] count_ff;
   logic [aesl_pkg::QCNT_W-1:0] count_in;
   logic                        pop;

   assign rsp_valid = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // room for the largest burst of one item
   assign space_ok  = (count_ff <= aesl_pkg::QCNT_W'(aesl_pkg::QUEUE_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + aesl_pkg::QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + aesl_pkg::QPTR_W'(pop);
      count_in  = count_ff + aesl_pkg::QCNT_W'(push.count) - aesl_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= aesl_pkg::QCNT_W'(aesl_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   push_only_with_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> space_ok && push.count != 2'd3)
      else $error("push without room");

endmodule
